[hdl/assert_macros.svh]
// assertion macros shared by the rtl that carries checks
// expects a clock named clk and a synchronous active-high reset named rst in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define AST_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// expression holds at every clock edge out of reset
`define AST_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error(msg);

`endif

[hdl/mevm_pkg.sv]
// shared constants, types and helpers of the midi event mapper
// no dependencies; imported by mevm_cell and the top level
`default_nettype none

package mevm_pkg;

  // table geometry
  localparam int ENTRIES = 32;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int WORD_W  = 15;

  // item function codes
  localparam logic [1:0] FUNC_EVENT  = 2'd0;
  localparam logic [1:0] FUNC_BEGIN  = 2'd1;
  localparam logic [1:0] FUNC_REG    = 2'd2;
  localparam logic [1:0] FUNC_REMOVE = 2'd3;

  // what a cell flags as a hit during evaluation
  localparam logic [1:0] SEL_MATCH = 2'd0;  // valid and full word equal
  localparam logic [1:0] SEL_VALID = 2'd1;  // any valid entry
  localparam logic [1:0] SEL_AFTER = 2'd2;  // valid entry above the pointer
  localparam logic [1:0] SEL_ADDR  = 2'd3;  // valid entry at the addressed index

  // evaluation command broadcast to every cell
  typedef struct packed {
    logic              eval;
    logic [1:0]        hsel;
    logic [WORD_W-1:0] key;
    logic [IDX_W-1:0]  ptr;
    logic [IDX_W-1:0]  addr;
    logic              addr_ok;
  } cell_cmd_t;

  // table write broadcast to every cell
  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  addr;
    logic              valid_val;
    logic              word_we;
    logic [WORD_W-1:0] word;
  } cell_wr_t;

  // type in 14..11, channel in 10..7, note in 6..0
  function automatic logic [WORD_W-1:0] pack_word(input logic [3:0] mtype,
                                                  input logic [3:0] chan,
                                                  input logic [6:0] nt);
    return {mtype, chan, nt};
  endfunction

endpackage

`default_nettype wire

[hdl/mevm_cell.sv]
// one table entry of the mapper: valid bit, packed word and registered hit flags
// depends on mevm_pkg; a row of these forms a first-hit priority chain
`default_nettype none

module mevm_cell (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic [mevm_pkg::IDX_W-1:0] my_idx,
  input  wire mevm_pkg::cell_cmd_t      cmd,
  input  wire mevm_pkg::cell_wr_t       wr,
  input  wire logic                     prefix_in,   // a lower cell already hit
  output logic                          prefix_out,
  output logic                          first,       // lowest hit in the row
  output logic                          tok,         // pointed entry type matches
  output logic                          valid
);
  import mevm_pkg::*;

  logic [WORD_W-1:0] word;
  logic              hit;
  logic              hit_next;
  logic              tok_next;

  // hit condition for the current command
  always_comb begin
    case (cmd.hsel)
      SEL_MATCH: hit_next = valid && (word == cmd.key);
      SEL_VALID: hit_next = valid;
      SEL_AFTER: hit_next = valid && (my_idx > cmd.ptr);
      default:   hit_next = valid && cmd.addr_ok && (my_idx == cmd.addr);
    endcase
    tok_next = (my_idx == cmd.ptr) && (word[14:11] == cmd.key[14:11]);
  end

  // flags captured on the evaluation beat
  always_ff @(posedge clk) begin
    if (rst) begin
      hit <= 1'b0;
      tok <= 1'b0;
    end else if (cmd.eval) begin
      hit <= hit_next;
      tok <= tok_next;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (wr.en && (wr.addr == my_idx)) begin
      valid <= wr.valid_val;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en && wr.word_we && (wr.addr == my_idx)) begin
      word <= wr.word;
    end
  end

  // priority chain toward higher indexes
  assign first      = hit && !prefix_in;
  assign prefix_out = hit || prefix_in;

endmodule

`default_nettype wire

[hdl/midi_event_mapper_with_learning_unit.sv]
// top level of the midi event mapper with learning mode
// depends on mevm_pkg, mevm_cell and assert_macros.svh
`default_nettype none
//
// Usage:
//   Items enter on the slave stream: s_tuser carries the function code
//   (event, begin learning, register, remove), s_tdata the entry index,
//   message type, channel and note. Each item yields exactly one result beat
//   on the master stream with dispatch, learn, learning flag and error fields.
//   Every table entry lives in its own cell of a row; on the accept beat all
//   cells compare the item against their entry in parallel and register a hit,
//   and in the resolve step a first-hit chain through the row picks the lowest
//   hitting entry; once the output register is free or being read, the table
//   is updated and the result is loaded. The block takes no new item until
//   the current one has left its resolve step.
//   A result waiting in the output register does not block the next accept;
//   if the receiver holds m_tready low while a second result is ready, the
//   block waits in its resolve step and takes no further item.
//   Reset clears all valid bits, learning mode and the pointer;
//   entry words are left as they are and are only read through valid bits.
//
`include "assert_macros.svh"

module midi_event_mapper_with_learning_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // entry_index[4:0], msg_type[8:5], channel[12:9],
                                      // note[19:13], zero fill
  input  wire logic [1:0]  s_tuser,   // func[1:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata    // dispatched[0], dispatch_index[5:1], learned[6],
                                      // learned_index[11:7], learning_active[12],
                                      // not_found_error[13], zero fill
);
  import mevm_pkg::*;

  localparam logic ST_IDLE    = 1'b0;
  localparam logic ST_RESOLVE = 1'b1;

  logic             state;
  logic             learning_on;
  logic [IDX_W-1:0] learn_pointer;

  // captured item
  logic [1:0]       func;
  logic [4:0]       entry_index;
  logic [3:0]       msg_type;
  logic [3:0]       channel;
  logic [6:0]       note;

  logic             in_beat;
  logic             commit;
  cell_cmd_t        cmd;
  cell_wr_t         wr;

  logic [ENTRIES:0]   prefix;
  logic [ENTRIES-1:0] first_vec;
  logic [ENTRIES-1:0] tok_vec;
  logic [ENTRIES-1:0] valid_vec;
  logic               any_hit;
  logic               tok_any;
  logic [IDX_W-1:0]   first_idx;

  // result of the item in resolve
  logic             learning_on_next;
  logic [IDX_W-1:0] learn_pointer_next;
  logic             res_dispatched;
  logic [4:0]       res_dispatch_index;
  logic             res_learned;
  logic [4:0]       res_learned_index;
  logic             res_not_found;

  assign s_tready = (state == ST_IDLE);
  assign in_beat  = s_tvalid && s_tready;
  assign commit   = (state == ST_RESOLVE) && (!m_tvalid || m_tready);

  // evaluation command built straight from the incoming beat
  always_comb begin
    cmd.eval    = in_beat;
    cmd.key     = pack_word(s_tdata[8:5], s_tdata[12:9], s_tdata[19:13]);
    cmd.ptr     = learn_pointer;
    cmd.addr    = IDX_W'(s_tdata[4:0]);
    cmd.addr_ok = (32'(s_tdata[4:0]) < 32'(ENTRIES));
    case (s_tuser)
      FUNC_EVENT: cmd.hsel = learning_on ? SEL_AFTER : SEL_MATCH;
      FUNC_BEGIN: cmd.hsel = SEL_VALID;
      default:    cmd.hsel = SEL_ADDR;
    endcase
  end

  // row of entry cells
  assign prefix[0] = 1'b0;
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    mevm_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .my_idx     (IDX_W'(i)),
      .cmd        (cmd),
      .wr         (wr),
      .prefix_in  (prefix[i]),
      .prefix_out (prefix[i+1]),
      .first      (first_vec[i]),
      .tok        (tok_vec[i]),
      .valid      (valid_vec[i])
    );
  end

  assign any_hit = prefix[ENTRIES];
  assign tok_any = |tok_vec;

  // one-hot first hit to index
  always_comb begin
    first_idx = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (first_vec[i]) begin
        first_idx = first_idx | IDX_W'(i);
      end
    end
  end

  // resolve the item: table write, mode update and result fields
  always_comb begin
    learning_on_next   = learning_on;
    learn_pointer_next = learn_pointer;
    res_dispatched     = 1'b0;
    res_dispatch_index = '0;
    res_learned        = 1'b0;
    res_learned_index  = '0;
    res_not_found      = 1'b0;
    wr.en              = 1'b0;
    wr.addr            = IDX_W'(entry_index);
    wr.valid_val       = 1'b1;
    wr.word_we         = 1'b0;
    wr.word            = pack_word(msg_type, channel, note);
    unique case (func)
      FUNC_EVENT: begin
        if (learning_on) begin
          if (tok_any) begin
            wr.en             = commit;
            wr.addr           = learn_pointer;
            wr.word_we        = 1'b1;
            res_learned       = 1'b1;
            res_learned_index = 5'(learn_pointer);
            if (any_hit) begin
              learn_pointer_next = first_idx;
            end else begin
              learning_on_next   = 1'b0;
              learn_pointer_next = '0;
            end
          end
        end else begin
          res_dispatched     = any_hit;
          res_dispatch_index = 5'(first_idx);
        end
      end
      FUNC_BEGIN: begin
        if (any_hit) begin
          learning_on_next   = 1'b1;
          learn_pointer_next = first_idx;
        end else begin
          learning_on_next   = 1'b0;
          learn_pointer_next = '0;
        end
      end
      FUNC_REG: begin
        if (!learning_on && (32'(entry_index) < 32'(ENTRIES))) begin
          wr.en      = commit;
          wr.word_we = 1'b1;
        end
      end
      default: begin
        if (!learning_on) begin
          if (any_hit) begin
            wr.en        = commit;
            wr.valid_val = 1'b0;
          end else begin
            res_not_found = 1'b1;
          end
        end
      end
    endcase
  end

  // control: state, learning mode, pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      learning_on   <= 1'b0;
      learn_pointer <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_beat) begin
            state <= ST_RESOLVE;
          end
        end
        default: begin
          if (commit) begin
            state         <= ST_IDLE;
            learning_on   <= learning_on_next;
            learn_pointer <= learn_pointer_next;
          end
        end
      endcase
    end
  end

  // captured item fields
  always_ff @(posedge clk) begin
    if (in_beat) begin
      func        <= s_tuser;
      entry_index <= s_tdata[4:0];
      msg_type    <= s_tdata[8:5];
      channel     <= s_tdata[12:9];
      note        <= s_tdata[19:13];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (commit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      m_tdata <= {2'b00, res_not_found, learning_on_next, res_learned_index,
                  res_learned, res_dispatch_index, res_dispatched};
    end
  end

  // checks
  `AST_ALWAYS(a_first_onehot, $onehot0(first_vec), "more than one first hit in the row")
  `AST_IMPL(a_ptr_valid, learning_on, valid_vec[learn_pointer],
            "learn pointer rests on an invalid entry")
  `AST_IMPL(a_out_from_resolve, $rose(m_tvalid), $past(state) == ST_RESOLVE,
            "result beat raised outside resolve")
  `AST_IMPL(a_no_accept_busy, state == ST_RESOLVE, !s_tready,
            "input accepted while an item is resolving")

endmodule

`default_nettype wire
